/* rtl/core/skds_pkg.sv */
package skds_pkg;

    localparam int DIRECTORY_DEPTH = 2048;
    localparam int MAX_RETURNED    = 24;
    localparam int CANDIDATE_BYTES = 3;

    localparam int KEY_W    = 56;
    localparam int SLOT_W   = 11;
    localparam int OFFSET_W = 18;
    localparam int COUNT_W  = 11;
    localparam int LIMIT_W  = 10;
    localparam int RCOUNT_W = 12;
    localparam int DSIZE_W  = 19;
    localparam int OCOUNT_W = 5;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam int ENTRY_W = KEY_W + OFFSET_W + COUNT_W;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 24;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE_ERR = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_INDEX_READY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_SIZE    = 2'd2;

endpackage

/* rtl/core/skds_dir_ram.sv */
module skds_dir_ram #(
    parameter int DEPTH = skds_pkg::DIRECTORY_DEPTH,
    parameter int AW    = 11,
    parameter int DW    = skds_pkg::ENTRY_W
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/sorted_key_directory_search.sv */
// Write request: taken while idle, no result.
// Search request: result follows P probes, each a directory read and a compare (P up to
// ceil(log2(N+1)), 12 at 2048 entries); rejection and empty range finish without a probe.
// One request at a time; each probe costs a read and a compare on the single directory port.
// Reset (i_rst_n low, synchronous) clears control and configuration registers; directory
// contents are undefined until written and get no clearing pass.
module sorted_key_directory_search #(
    parameter int DIRECTORY_DEPTH = skds_pkg::DIRECTORY_DEPTH,
    parameter int MAX_RETURNED    = skds_pkg::MAX_RETURNED
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_index, key, entry_offset, entry_count, result_limit, zero fill
    input  logic [skds_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // opcode
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // data_offset, candidate_count, zero fill
    output logic [skds_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // status
    output logic [skds_pkg::STATUS_W-1:0]       m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [skds_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [skds_pkg::DSIZE_W-1:0]        i_cfg_data
);

    localparam int AW = (DIRECTORY_DEPTH > 1) ? $clog2(DIRECTORY_DEPTH) : 1;
    localparam int BW = ($clog2(DIRECTORY_DEPTH + 1) > skds_pkg::RCOUNT_W)
                        ? $clog2(DIRECTORY_DEPTH + 1) : skds_pkg::RCOUNT_W;
    localparam int CW  = skds_pkg::COUNT_W;
    localparam int C3W = skds_pkg::COUNT_W + 2;
    localparam int DSW = skds_pkg::DSIZE_W;
    localparam int OFW = skds_pkg::OFFSET_W;
    localparam int KW  = skds_pkg::KEY_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_CMP,
        S_CHK,
        S_DONE
    } t_state;

    t_state r_state;

    logic                              r_index_ready;
    logic [skds_pkg::RCOUNT_W-1:0]     r_record_count;
    logic [DSW-1:0]                    r_data_size;

    logic [KW-1:0]                     r_key;
    logic [skds_pkg::LIMIT_W-1:0]      r_limit;
    logic [BW-1:0]                     r_low;
    logic [BW-1:0]                     r_high;
    logic [BW-1:0]                     r_mid;
    logic [OFW-1:0]                    r_hit_offset;
    logic [CW-1:0]                     r_hit_count;

    logic [skds_pkg::STATUS_W-1:0]     r_res_status;
    logic [OFW-1:0]                    r_res_offset;
    logic [skds_pkg::OCOUNT_W-1:0]     r_res_cnt;

    logic                              r_out_valid;
    logic [skds_pkg::STATUS_W-1:0]     r_out_status;
    logic [OFW-1:0]                    r_out_offset;
    logic [skds_pkg::OCOUNT_W-1:0]     r_out_cnt;

    logic [skds_pkg::SLOT_W-1:0]       in_slot;
    logic [KW-1:0]                     in_key;
    logic [OFW-1:0]                    in_offset;
    logic [CW-1:0]                     in_count;
    logic [skds_pkg::LIMIT_W-1:0]      in_limit;

    logic                              in_accept;
    logic [BW-1:0]                     slot_ext;
    logic                              slot_ok;
    logic [BW-1:0]                     rc_ext;
    logic [BW-1:0]                     high_init;
    logic [BW-1:0]                     n_mid;
    logic                              mem_we;
    logic [AW-1:0]                     mem_addr;
    logic [skds_pkg::ENTRY_W-1:0]      mem_wdata;
    logic [skds_pkg::ENTRY_W-1:0]      mem_rdata;
    logic [KW-1:0]                     probe_key;
    logic [skds_pkg::LIMIT_W-1:0]      cap;
    logic [CW-1:0]                     clamp_cnt;
    logic [C3W-1:0]                    cnt_bytes;
    logic [DSW-1:0]                    room;
    logic                              range_bad;
    logic                              out_load;

    assign in_slot   = s_axis_tdata[10:0];
    assign in_key    = s_axis_tdata[66:11];
    assign in_offset = s_axis_tdata[84:67];
    assign in_count  = s_axis_tdata[95:85];
    assign in_limit  = s_axis_tdata[105:96];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign slot_ext  = BW'(in_slot);
    assign slot_ok   = slot_ext < BW'(DIRECTORY_DEPTH);
    assign rc_ext    = BW'(r_record_count);
    assign high_init = (rc_ext > BW'(DIRECTORY_DEPTH)) ? BW'(DIRECTORY_DEPTH) : rc_ext;
    assign n_mid     = r_low + ((r_high - r_low) >> 1);

    assign mem_we    = in_accept && (s_axis_tuser == skds_pkg::OP_WRITE) && slot_ok;
    assign mem_addr  = (r_state == S_IDLE) ? slot_ext[AW-1:0] : n_mid[AW-1:0];
    assign mem_wdata = {in_key, in_offset, in_count};
    assign probe_key = mem_rdata[skds_pkg::ENTRY_W-1 -: KW];

    assign cap       = (r_limit < skds_pkg::LIMIT_W'(MAX_RETURNED))
                       ? r_limit : skds_pkg::LIMIT_W'(MAX_RETURNED);
    assign clamp_cnt = (r_hit_count < CW'(cap)) ? r_hit_count : CW'(cap);
    assign cnt_bytes = C3W'(clamp_cnt) * C3W'(skds_pkg::CANDIDATE_BYTES);
    assign room      = r_data_size - DSW'(r_hit_offset);
    assign range_bad = (DSW'(r_hit_offset) > r_data_size) || (DSW'(cnt_bytes) > room);

    assign out_load  = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    skds_dir_ram #(
        .DEPTH (DIRECTORY_DEPTH),
        .AW    (AW),
        .DW    (skds_pkg::ENTRY_W)
    ) u_dir (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_ready  <= 1'b0;
            r_record_count <= '0;
            r_data_size    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                skds_pkg::REG_INDEX_READY:  r_index_ready  <= i_cfg_data[0];
                skds_pkg::REG_RECORD_COUNT: r_record_count <= i_cfg_data[skds_pkg::RCOUNT_W-1:0];
                skds_pkg::REG_DATA_SIZE:    r_data_size    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept && (s_axis_tuser == skds_pkg::OP_SEARCH)) begin
                        r_key   <= in_key;
                        r_limit <= in_limit;
                        r_low   <= '0;
                        r_high  <= high_init;
                        if (!r_index_ready || (in_key == '0) || (in_limit == '0)) begin
                            r_res_status <= skds_pkg::ST_REJECTED;
                            r_res_offset <= '0;
                            r_res_cnt    <= '0;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_ADDR;
                        end
                    end
                end
                S_ADDR: begin
                    if (r_low < r_high) begin
                        r_mid   <= n_mid;
                        r_state <= S_CMP;
                    end else begin
                        r_res_status <= skds_pkg::ST_NOT_FOUND;
                        r_res_offset <= '0;
                        r_res_cnt    <= '0;
                        r_state      <= S_DONE;
                    end
                end
                S_CMP: begin
                    if (probe_key < r_key) begin
                        r_low   <= r_mid + BW'(1);
                        r_state <= S_ADDR;
                    end else if (probe_key > r_key) begin
                        r_high  <= r_mid;
                        r_state <= S_ADDR;
                    end else begin
                        r_hit_offset <= mem_rdata[CW +: OFW];
                        r_hit_count  <= mem_rdata[CW-1:0];
                        r_state      <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (range_bad) begin
                        r_res_status <= skds_pkg::ST_RANGE_ERR;
                        r_res_offset <= '0;
                        r_res_cnt    <= '0;
                    end else begin
                        r_res_status <= skds_pkg::ST_FOUND;
                        r_res_offset <= r_hit_offset;
                        r_res_cnt    <= clamp_cnt[skds_pkg::OCOUNT_W-1:0];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_res_status;
                r_out_offset <= r_res_offset;
                r_out_cnt    <= r_res_cnt;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {1'b0, r_out_cnt, r_out_offset};

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_low < r_high))
        else $error("probe issued on an empty range");

    a_cmp_after_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ($past(r_state) == S_ADDR))
        else $error("compare without a preceding directory read");

    a_miss_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != skds_pkg::ST_FOUND))
        |-> ((r_out_offset == '0) && (r_out_cnt == '0)))
        else $error("non-zero payload on a miss");

    a_hit_within_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == skds_pkg::ST_FOUND))
        |-> ((DSW'(r_out_offset) + DSW'(r_out_cnt) * DSW'(skds_pkg::CANDIDATE_BYTES))
             <= r_data_size))
        else $error("found result overruns the data area");

endmodule
